>>> rtl/core/keyed_stat_counter_table_top_assert.svh
// Assertion macros used by the keyed statistics counter table datapath.
`ifndef KEYED_STAT_COUNTER_TABLE_TOP_ASSERT_SVH
`define KEYED_STAT_COUNTER_TABLE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, muted while rst_n is low.
`define KSC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, sampled on clk, muted while rst_n is low.
`define KSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define KSC_ASSERT_IMPLIES(lbl, ante, cons)
`define KSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/kscnt_pkg.sv
// Types, codes and microcode table of the keyed statistics counter table.
`default_nettype none
package kscnt_pkg;

  localparam int KEY_W = 64;
  localparam int VAL_W = 64;

  localparam logic [1:0] MODE_SET  = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;
  localparam logic [1:0] MODE_NOP  = 2'd3;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INDEX    = 3'd1,
    ST_INVALID  = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Microprogram step addresses.
  typedef enum logic [3:0] {
    U_CLR  = 4'd0,
    U_IDLE = 4'd1,
    U_CHK  = 4'd2,
    U_SCAN = 4'd3,
    U_CMP  = 4'd4,
    U_HRD  = 4'd5,
    U_HWB  = 4'd6,
    U_MISS = 4'd7,
    U_APP  = 4'd8,
    U_DONE = 4'd9
  } upc_t;

  // Branch conditions.
  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_START     = 3'd1,
    C_PREFAIL   = 3'd2,
    C_SCAN_END  = 3'd3,
    C_MATCH     = 3'd4,
    C_MISS_STOP = 3'd5,
    C_CLR_LAST  = 3'd6
  } cond_t;

  // One control word.
  typedef struct packed {
    logic  busy;
    logic  latch;
    logic  pre;
    logic  key_rd;
    logic  slot_step;
    logic  cnt_rd;
    logic  cnt_wb;
    logic  miss;
    logic  append;
    logic  done;
    logic  clr;
    cond_t cond;
    upc_t  tgt_t;
    upc_t  tgt_f;
  } ucw_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic start;
    logic pre_fail;
    logic scan_end;
    logic match;
    logic miss_stop;
    logic clr_last;
  } flags_t;

  function automatic ucw_t ucode_rom(upc_t a);
    ucw_t w;
    w       = '0;
    w.busy  = 1'b1;
    w.cond  = C_ALWAYS;
    w.tgt_t = U_IDLE;
    w.tgt_f = U_IDLE;
    case (a)
      U_CLR: begin
        w.clr   = 1'b1;
        w.cond  = C_CLR_LAST;
        w.tgt_t = U_IDLE;
        w.tgt_f = U_CLR;
      end
      U_IDLE: begin
        w.busy  = 1'b0;
        w.latch = 1'b1;
        w.cond  = C_START;
        w.tgt_t = U_CHK;
        w.tgt_f = U_IDLE;
      end
      U_CHK: begin
        w.pre   = 1'b1;
        w.cond  = C_PREFAIL;
        w.tgt_t = U_DONE;
        w.tgt_f = U_SCAN;
      end
      U_SCAN: begin
        w.key_rd = 1'b1;
        w.cond   = C_SCAN_END;
        w.tgt_t  = U_MISS;
        w.tgt_f  = U_CMP;
      end
      U_CMP: begin
        w.slot_step = 1'b1;
        w.cond      = C_MATCH;
        w.tgt_t     = U_HRD;
        w.tgt_f     = U_SCAN;
      end
      U_HRD: begin
        w.cnt_rd = 1'b1;
        w.tgt_t  = U_HWB;
        w.tgt_f  = U_HWB;
      end
      U_HWB: begin
        w.cnt_wb = 1'b1;
        w.tgt_t  = U_DONE;
        w.tgt_f  = U_DONE;
      end
      U_MISS: begin
        w.miss  = 1'b1;
        w.cond  = C_MISS_STOP;
        w.tgt_t = U_DONE;
        w.tgt_f = U_APP;
      end
      U_APP: begin
        w.append = 1'b1;
        w.tgt_t  = U_DONE;
        w.tgt_f  = U_DONE;
      end
      U_DONE: begin
        w.done  = 1'b1;
        w.tgt_t = U_IDLE;
        w.tgt_f = U_IDLE;
      end
      default: begin
        w.tgt_t = U_IDLE;
        w.tgt_f = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/keyed_stat_counter_table_top.sv
// Top level of the keyed statistics counter table.
//
// Keyed statistics counter table. Each request names a module, a 64-bit table
// id and a counter index, and sets, adds to or reads one signed 64-bit counter.
// A request transfers on a rising edge with start high and busy low; exactly
// one result follows as a single-cycle out_valid strobe with out_status and
// out_read_value, and the receiver cannot stall it, so capture it on that edge.
// Paths: a request refused by the early checks (no-op mode, all-ones key,
// module or index out of range) goes straight to the result strobe; a hit
// on a stored entry reads its counter and then writes it back or returns
// it; a miss either ends the run (read miss, full list) or appends a new
// entry. The key search is run by a microcoded sequencer that spends two
// steps per stored key, one for the registered key memory read and one for
// the compare. busy drops the cycle after the strobe.
// After reset a clearing pass zeros all 2^(clog2(MODULES)+clog2(TABLES)+
// clog2(COUNTERS)) words of the counter memory (2048 with the default sizes),
// one word per cycle; busy stays high until it ends.
`default_nettype none
module keyed_stat_counter_table_top #(
  parameter int MODULES  = 4,
  parameter int TABLES   = 16,
  parameter int COUNTERS = 32
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire  [1:0]         in_mode,
  input  wire  [1:0]         in_module_id,
  input  wire  [63:0]        in_tbl_key,
  input  wire  [7:0]         in_counter_index,
  input  wire  signed [63:0] in_operand_value,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic signed [63:0] out_read_value
);
  import kscnt_pkg::*;

  ucw_t        ctl;
  flags_t      flags;
  logic [2:0]  dp_status;
  logic [63:0] dp_value;

  // Step counter and control table: drive the datapath one word per cycle.
  kscnt_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  // Request hold, key search, counter read-modify-write and clearing pass.
  kscnt_datapath #(
    .MODULES  (MODULES),
    .TABLES   (TABLES),
    .COUNTERS (COUNTERS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .req_mode          (in_mode),
    .req_module_id     (in_module_id),
    .req_tbl_key       (in_tbl_key),
    .req_counter_index (in_counter_index),
    .req_operand_value (in_operand_value),
    .ctl               (ctl),
    .flags             (flags),
    .status            (dp_status),
    .read_value        (dp_value)
  );

  // The idle step is the only one that takes a transfer.
  assign busy           = ctl.busy;
  // The done step shows the held result for exactly one cycle.
  assign out_valid      = ctl.done;
  assign out_status     = dp_status;
  assign out_read_value = dp_value;

endmodule
`default_nettype wire

>>> rtl/core/kscnt_useq.sv
// Microcode sequencer: step counter, control table and branch logic.
`default_nettype none
module kscnt_useq (
  input  wire                clk,
  input  wire                rst_n,
  input  kscnt_pkg::flags_t  flags,
  output kscnt_pkg::ucw_t    ctl
);
  import kscnt_pkg::*;

  upc_t upc_r;
  upc_t upc_nxt;
  logic take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_CLR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  always_comb begin
    ctl = ucode_rom(upc_r);
    case (ctl.cond)
      C_ALWAYS:    take = 1'b1;
      C_START:     take = flags.start;
      C_PREFAIL:   take = flags.pre_fail;
      C_SCAN_END:  take = flags.scan_end;
      C_MATCH:     take = flags.match;
      C_MISS_STOP: take = flags.miss_stop;
      C_CLR_LAST:  take = flags.clr_last;
      default:     take = 1'b1;
    endcase
    upc_nxt = take ? ctl.tgt_t : ctl.tgt_f;
  end

endmodule
`default_nettype wire

>>> rtl/core/kscnt_datapath.sv
// Datapath: request registers, key memory, counter memory, entry counts.
`default_nettype none
`include "keyed_stat_counter_table_top_assert.svh"
module kscnt_datapath #(
  parameter int MODULES  = 4,
  parameter int TABLES   = 16,
  parameter int COUNTERS = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire  [1:0]          req_mode,
  input  wire  [1:0]          req_module_id,
  input  wire  [63:0]         req_tbl_key,
  input  wire  [7:0]          req_counter_index,
  input  wire  [63:0]         req_operand_value,
  input  kscnt_pkg::ucw_t     ctl,
  output kscnt_pkg::flags_t   flags,
  output logic [2:0]          status,
  output logic [63:0]         read_value
);
  import kscnt_pkg::*;

  localparam int MW    = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int TW    = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int CW    = (COUNTERS > 1) ? $clog2(COUNTERS) : 1;
  localparam int NW    = $clog2(TABLES + 1);
  localparam int KAW   = MW + TW;
  localparam int CAW   = KAW + CW;
  localparam int KDEPTH = 1 << KAW;
  localparam int CDEPTH = 1 << CAW;

  logic [1:0]       mode_r;
  logic [1:0]       mod_r;
  logic [KEY_W-1:0] key_r;
  logic [7:0]       idx_r;
  logic [VAL_W-1:0] opv_r;

  logic [NW-1:0]    cnt_r [MODULES];
  logic [NW-1:0]    slot_r;
  logic [CAW-1:0]   clr_r;
  logic [KEY_W-1:0] key_rd_r;
  logic [VAL_W-1:0] cnt_rd_r;
  status_t          status_r;
  logic [VAL_W-1:0] rv_r;

  logic [KEY_W-1:0] key_mem [KDEPTH];
  logic [VAL_W-1:0] cnt_mem [CDEPTH];

  logic [MW-1:0]    mod_ix;
  logic [CW-1:0]    idx_ix;
  logic [NW-1:0]    cnt_cur;
  logic             full;
  logic             pre_fail;
  status_t          pre_code;
  logic [KAW-1:0]   key_rd_addr;
  logic [KAW-1:0]   key_wr_addr;
  logic [CAW-1:0]   hit_addr;
  logic [CAW-1:0]   cnt_wr_addr;
  logic [VAL_W-1:0] cnt_wr_data;
  logic             cnt_we;
  logic             key_match;

  assign mod_ix   = MW'(mod_r);
  assign idx_ix   = CW'(idx_r);
  assign cnt_cur  = cnt_r[mod_ix];
  assign full     = (cnt_cur >= NW'(TABLES));
  assign key_match = (key_rd_r == key_r);

  assign key_rd_addr = {mod_ix, slot_r[TW-1:0]};
  assign key_wr_addr = {mod_ix, cnt_cur[TW-1:0]};
  assign hit_addr    = {mod_ix, slot_r[TW-1:0], idx_ix};

  // Checks in priority order: no-op mode, bad key or module, bad index.
  always_comb begin
    pre_fail = 1'b0;
    pre_code = ST_OK;
    if (mode_r == MODE_NOP) begin
      pre_fail = 1'b1;
    end else if ((&key_r) || (32'(mod_r) >= 32'(MODULES))) begin
      pre_fail = 1'b1;
      pre_code = ST_INVALID;
    end else if (32'(idx_r) >= 32'(COUNTERS)) begin
      pre_fail = 1'b1;
      pre_code = ST_INDEX;
    end
  end

  always_comb begin
    cnt_we      = 1'b0;
    cnt_wr_addr = hit_addr;
    cnt_wr_data = opv_r;
    if (ctl.clr) begin
      cnt_we      = 1'b1;
      cnt_wr_addr = clr_r;
      cnt_wr_data = '0;
    end else if (ctl.append) begin
      cnt_we      = 1'b1;
      cnt_wr_addr = {mod_ix, cnt_cur[TW-1:0], idx_ix};
    end else if (ctl.cnt_wb && (mode_r != MODE_READ)) begin
      cnt_we = 1'b1;
      if (mode_r == MODE_ADD) begin
        cnt_wr_data = cnt_rd_r + opv_r;
      end
    end
  end

  assign flags.start     = start;
  assign flags.pre_fail  = pre_fail;
  assign flags.scan_end  = (slot_r >= cnt_cur);
  assign flags.match     = key_match;
  assign flags.miss_stop = (mode_r == MODE_READ) || full;
  assign flags.clr_last  = &clr_r;

  // Hold the request for the whole program run.
  always_ff @(posedge clk) begin
    if (ctl.latch && start) begin
      mode_r <= req_mode;
      mod_r  <= req_module_id;
      key_r  <= req_tbl_key;
      idx_r  <= req_counter_index;
      opv_r  <= req_operand_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < MODULES; m++) begin
        cnt_r[m] <= '0;
      end
      clr_r <= '0;
    end else begin
      if (ctl.clr) begin
        clr_r <= clr_r + 1'b1;
      end
      if (ctl.append) begin
        cnt_r[mod_ix] <= cnt_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pre) begin
      slot_r <= '0;
    end else if (ctl.slot_step && !key_match) begin
      slot_r <= slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pre) begin
      status_r <= pre_code;
      rv_r     <= '0;
    end else if (ctl.miss) begin
      if (mode_r == MODE_READ) begin
        status_r <= ST_NOTFOUND;
      end else if (full) begin
        status_r <= ST_FULL;
      end
    end else if (ctl.cnt_wb && (mode_r == MODE_READ)) begin
      rv_r <= cnt_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.append) begin
      key_mem[key_wr_addr] <= key_r;
    end
    if (ctl.key_rd) begin
      key_rd_r <= key_mem[key_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wr_addr] <= cnt_wr_data;
    end
    if (ctl.cnt_rd) begin
      cnt_rd_r <= cnt_mem[hit_addr];
    end
  end

  assign status     = status_r;
  assign read_value = rv_r;

  // Append only after the whole list was searched and only with room left.
  `KSC_ASSERT_IMPLIES(a_append_after_scan, ctl.append, slot_r == cnt_cur)
  `KSC_ASSERT_IMPLIES(a_append_room, ctl.append, cnt_cur < NW'(TABLES))
  // A hit write-back addresses an entry in use.
  `KSC_ASSERT_IMPLIES(a_hit_in_list, ctl.cnt_wb, slot_r < cnt_cur)
  // Result strobe lasts one cycle; a transfer makes the block busy.
  `KSC_ASSERT_NEXT(a_strobe_single, ctl.done, !ctl.done)
  `KSC_ASSERT_NEXT(a_busy_after_start, ctl.latch && start, ctl.busy)

endmodule
`default_nettype wire
